// ===== rtl/planar_texture_uv_projection_defines.svh =====
// Assertion macros for the planar UV projection block.
// Used by the top level only; no other dependencies.
`ifndef PLANAR_TEXTURE_UV_PROJECTION_DEFINES_SVH
`define PLANAR_TEXTURE_UV_PROJECTION_DEFINES_SVH
// implication checked on every clock, idle in reset
`define PTUV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// consequence in the cycle after antecedent
`define PTUV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

// ===== rtl/ptuv_pkg.sv =====
// Shared types and constants for the planar UV projection block.
// No dependencies.
package ptuv_pkg;
    localparam int CoordW = 24;
    localparam int QuotW  = 48;
    localparam int DivW   = 16;
    localparam int DivStages = 8;
    localparam int BitsPerStage = QuotW / DivStages;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] REG_ROT_COS  = 3'd0;
    localparam logic [2:0] REG_ROT_SIN  = 3'd1;
    localparam logic [2:0] REG_SCALE_U  = 3'd2;
    localparam logic [2:0] REG_SCALE_V  = 3'd3;
    localparam logic [2:0] REG_OFFSET_U = 3'd4;
    localparam logic [2:0] REG_OFFSET_V = 3'd5;

    localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

    // state of one lane in the divider pipeline
    typedef struct packed {
        logic [QuotW-1:0] quo;
        logic [DivW-1:0]  rem;
        logic             neg;
        logic             zero;
        logic [DivW-1:0]  scale;
        logic signed [31:0] off;
    } div_lane_t;
endpackage

// ===== rtl/ptuv_div.sv =====
// Pipelined unsigned restoring divider lane with Q16.16 saturation and offset.
// Depends on ptuv_pkg.
module ptuv_div
    import ptuv_pkg::*;
(
    input  logic                  clk,
    input  logic                  adv,
    input  logic signed [40:0]    r,
    input  logic [DivW-1:0]       scale,
    input  logic signed [31:0]    off,
    output logic signed [31:0]    res,
    output logic                  flag
);
    div_lane_t st_reg [DivStages+1];
    div_lane_t st_next [DivStages+1];
    logic [QuotW-1:0] mag;

    always_comb
    begin
        logic [DivW:0] trial;
        div_lane_t     w;
        // dividend is 4*|R|
        mag = r[40] ? QuotW'(-(r <<< 2)) : QuotW'(r <<< 2);
        st_next[0].quo   = mag;
        st_next[0].rem   = '0;
        st_next[0].neg   = r[40];
        st_next[0].zero  = (scale == '0);
        st_next[0].scale = scale;
        st_next[0].off   = off;
        trial = '0;
        for (int g = 0; g < DivStages; g++)
        begin
            w = st_reg[g];
            for (int b = 0; b < BitsPerStage; b++)
            begin
                trial = {w.rem, w.quo[QuotW-1]} - {1'b0, w.scale};
                if (!trial[DivW])
                begin
                    w.rem = trial[DivW-1:0];
                    w.quo = {w.quo[QuotW-2:0], 1'b1};
                end
                else
                begin
                    w.rem = {w.rem[DivW-2:0], w.quo[QuotW-1]};
                    w.quo = {w.quo[QuotW-2:0], 1'b0};
                end
            end
            st_next[g+1] = w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= DivStages; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // final: sign, clamp, offset, clamp
    logic signed [49:0] q;
    logic signed [49:0] s;
    div_lane_t fin;
    always_comb
    begin
        fin = st_reg[DivStages];
        q = fin.neg ? -$signed({2'b00, fin.quo}) : $signed({2'b00, fin.quo});
        s = '0;
        flag = 1'b0;
        if (fin.zero)
        begin
            flag = 1'b1;
            res = fin.neg ? Q32_MIN : Q32_MAX;
        end
        else
        begin
            if (q > 50'sd2147483647)
            begin
                q = 50'sd2147483647;
                flag = 1'b1;
            end
            else if (q < -50'sd2147483648)
            begin
                q = -50'sd2147483648;
                flag = 1'b1;
            end
            s = q + 50'(fin.off);
            if (s > 50'sd2147483647)
            begin
                res = Q32_MAX;
                flag = 1'b1;
            end
            else if (s < -50'sd2147483648)
            begin
                res = Q32_MIN;
                flag = 1'b1;
            end
            else
            begin
                res = s[31:0];
            end
        end
    end
endmodule

// ===== rtl/planar_texture_uv_projection.sv =====
// Planar UV projection: one item per cycle from start to done.
// Stages: edges, cross products, axis pick, rotate, magnitude, 8 divider stages, clamp.
// The divider pipeline (6 quotient bits per stage) sets the depth.
// The receiver cannot stall, so busy is always low.
// Reset clears valid bits and registers to their reset values; data is unreset.
`include "planar_texture_uv_projection_defines.svh"
module planar_texture_uv_projection
    import ptuv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CoordW-1:0] pos_x,
    input  logic signed [CoordW-1:0] pos_y,
    input  logic signed [CoordW-1:0] pos_z,
    input  logic signed [CoordW-1:0] plane_a_x,
    input  logic signed [CoordW-1:0] plane_a_y,
    input  logic signed [CoordW-1:0] plane_a_z,
    input  logic signed [CoordW-1:0] plane_b_x,
    input  logic signed [CoordW-1:0] plane_b_y,
    input  logic signed [CoordW-1:0] plane_b_z,
    input  logic signed [CoordW-1:0] plane_c_x,
    input  logic signed [CoordW-1:0] plane_c_y,
    input  logic signed [CoordW-1:0] plane_c_z,
    output logic                     done,
    output logic signed [31:0]       tex_u,
    output logic signed [31:0]       tex_v,
    output logic [1:0]               major_axis,
    output logic                     range_flag,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    localparam int Lat = 4 + DivStages + 2;

    logic signed [15:0] rot_cos_reg, rot_sin_reg;
    logic [15:0]        scale_u_reg, scale_v_reg;
    logic signed [31:0] offset_u_reg, offset_v_reg;
    logic [2:0]         ridx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_cos_reg  <= 16'sd16384;
            rot_sin_reg  <= '0;
            scale_u_reg  <= 16'd256;
            scale_v_reg  <= 16'd256;
            offset_u_reg <= '0;
            offset_v_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_ROT_COS:  rot_cos_reg  <= pwdata[15:0];
                REG_ROT_SIN:  rot_sin_reg  <= pwdata[15:0];
                REG_SCALE_U:  scale_u_reg  <= pwdata[15:0];
                REG_SCALE_V:  scale_v_reg  <= pwdata[15:0];
                REG_OFFSET_U: offset_u_reg <= pwdata;
                REG_OFFSET_V: offset_v_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_ROT_COS:  prdata = {{16{rot_cos_reg[15]}}, rot_cos_reg};
            REG_ROT_SIN:  prdata = {{16{rot_sin_reg[15]}}, rot_sin_reg};
            REG_SCALE_U:  prdata = {16'd0, scale_u_reg};
            REG_SCALE_V:  prdata = {16'd0, scale_v_reg};
            REG_OFFSET_U: prdata = offset_u_reg;
            REG_OFFSET_V: prdata = offset_v_reg;
            default:      prdata = '0;
        endcase
    end

    // valid shift line; advance always (receiver never stalls)
    logic [Lat-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Lat-2:0], start};
    end

    // stage 1: edges
    logic signed [24:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [23:0] p1x_reg, p1y_reg, p1z_reg;
    // stage 2: products
    logic signed [49:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [23:0] p2x_reg, p2y_reg, p2z_reg;
    // stage 3: axis and selection
    logic [1:0]         ax3_reg;
    logic signed [23:0] u3_reg, v3_reg;
    // stage 4: rotation
    logic signed [40:0] ru_reg, rv_reg;
    // axis follows the rotation through magnitude and divider stages
    logic [1:0]         axp_reg [DivStages+2];

    logic signed [50:0] nx, ny, nz;
    logic [50:0]        anx, any_n, anz;
    logic [1:0]         ax_next;

    always_comb
    begin
        nx = 51'(m0_reg) - 51'(m1_reg);
        ny = 51'(m2_reg) - 51'(m3_reg);
        nz = 51'(m4_reg) - 51'(m5_reg);
        anx   = nx[50] ? 51'(-nx) : 51'(nx);
        any_n = ny[50] ? 51'(-ny) : 51'(ny);
        anz   = nz[50] ? 51'(-nz) : 51'(nz);
        priority if (any_n > anx && any_n > anz)
            ax_next = AXIS_Y;
        else if (anx > anz)
            ax_next = AXIS_X;
        else
            ax_next = AXIS_Z;
    end

    always_ff @(posedge clk)
    begin
        e1x_reg <= 25'(plane_b_x) - 25'(plane_a_x);
        e1y_reg <= 25'(plane_b_y) - 25'(plane_a_y);
        e1z_reg <= 25'(plane_b_z) - 25'(plane_a_z);
        e2x_reg <= 25'(plane_c_x) - 25'(plane_a_x);
        e2y_reg <= 25'(plane_c_y) - 25'(plane_a_y);
        e2z_reg <= 25'(plane_c_z) - 25'(plane_a_z);
        p1x_reg <= pos_x;
        p1y_reg <= pos_y;
        p1z_reg <= pos_z;

        m0_reg <= e1y_reg * e2z_reg;
        m1_reg <= e1z_reg * e2y_reg;
        m2_reg <= e1z_reg * e2x_reg;
        m3_reg <= e1x_reg * e2z_reg;
        m4_reg <= e1x_reg * e2y_reg;
        m5_reg <= e1y_reg * e2x_reg;
        p2x_reg <= p1x_reg;
        p2y_reg <= p1y_reg;
        p2z_reg <= p1z_reg;

        ax3_reg <= ax_next;
        unique case (ax_next)
            AXIS_X:  begin u3_reg <= p2y_reg; v3_reg <= p2z_reg; end
            AXIS_Y:  begin u3_reg <= p2x_reg; v3_reg <= p2z_reg; end
            default: begin u3_reg <= p2x_reg; v3_reg <= p2y_reg; end
        endcase

        ru_reg <= 41'(u3_reg * rot_cos_reg) - 41'(v3_reg * rot_sin_reg);
        rv_reg <= 41'(u3_reg * rot_sin_reg) + 41'(v3_reg * rot_cos_reg);

        axp_reg[0] <= ax3_reg;
        for (int i = 1; i <= DivStages + 1; i++)
            axp_reg[i] <= axp_reg[i-1];
    end

    logic signed [31:0] du, dv;
    logic               fu, fv;

    ptuv_div u_div_u (
        .clk(clk), .adv(1'b1), .r(ru_reg), .scale(scale_u_reg), .off(offset_u_reg),
        .res(du), .flag(fu)
    );
    ptuv_div u_div_v (
        .clk(clk), .adv(1'b1), .r(rv_reg), .scale(scale_v_reg), .off(offset_v_reg),
        .res(dv), .flag(fv)
    );

    always_ff @(posedge clk)
    begin
        tex_u      <= du;
        tex_v      <= dv;
        major_axis <= axp_reg[DivStages+1];
        range_flag <= fu | fv;
    end

    assign done = vld_reg[Lat-1];

    `PTUV_ASSERT_IMPLY(a_busy_low, 1'b1, !busy)
    `PTUV_ASSERT_IMPLY(a_axis_legal, done, major_axis != 2'd3)
    `PTUV_ASSERT_IMPLY(a_done_latency, done, $past(start, Lat))
    `PTUV_ASSERT_NEXT(a_start_tracked, start, vld_reg[0])
endmodule
